// ===== hw/rtl/priority_group_dose_sequencer_assert.svh =====
// Assertion macros shared by the dose sequencer RTL.
`ifndef PRIORITY_GROUP_DOSE_SEQUENCER_ASSERT_SVH
`define PRIORITY_GROUP_DOSE_SEQUENCER_ASSERT_SVH

// Same-cycle implication on the block clock, quiet in reset.
`define PGDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on the block clock, quiet in reset.
`define PGDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pgds_pkg.sv =====
package pgds_pkg;

	localparam int CHANNELS       = 24;
	localparam int SLOTS          = 6;
	localparam int COUNT_BITS_DEF = 16;

	localparam int PRIO_W    = 3;
	localparam int CHAN_W    = 5;
	localparam int CFG_W     = 54;
	localparam int CFG_IDX_W = 3;

	// slot setup register layout
	localparam int F_CHAN_LO = 0;
	localparam int F_EN      = 5;
	localparam int F_DIR     = 6;
	localparam int F_PRIO_LO = 7;
	localparam int F_ML_LO   = 10;
	localparam int ML_W      = 12;
	localparam int F_KA_LO   = 22;
	localparam int KA_W      = 16;
	localparam int F_KB_LO   = 38;
	localparam int KB_W      = 16;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic                opcode;
		logic [CHANNELS-1:0] encoder_levels;
	} in_item_t;

	typedef struct packed {
		logic [CHANNELS-1:0] pump_drive;
		logic [CHANNELS-1:0] direction_drive;
		logic                pumps_enable;
		logic [PRIO_W-1:0]   current_priority;
		logic [SLOTS-1:0]    finished_mask;
		logic                run_done;
	} out_item_t;

endpackage

// ===== hw/rtl/priority_group_dose_sequencer.sv =====
// An accepted item is held in the input register, then its result in the result register.
// One item per cycle if out_ready allows; edge counters and slot compares update in one pass.
// Slot targets are computed by one shared multiplier on each setup write.
// Reset (asynchronous): counters, targets and drive bits clear, all slots read as finished,
// the group pointer reads as SLOTS, setup registers clear and slot channels point at channel 0.
`include "priority_group_dose_sequencer_assert.svh"

module priority_group_dose_sequencer
	import pgds_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item
);

	localparam int TW = 34;
	localparam int PROD_W = ML_W + KA_W;
	localparam int SHR_W = PROD_W - 8;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [PRIO_W-1:0] PRIO_NONE = PRIO_W'(SLOTS);
	localparam logic [PRIO_W-1:0] PRIO_LAST = PRIO_W'(SLOTS - 1);

	// setup-derived slot attributes
	logic [CHANNELS-1:0]   cfg_oh_q   [SLOTS];
	logic [PRIO_W-1:0]     cfg_prio_q [SLOTS];
	logic [COUNT_BITS-1:0] cfg_tgt_q  [SLOTS];
	logic [SLOTS-1:0]      cfg_act_q;
	logic [SLOTS-1:0]      cfg_dir_q;

	// run state
	logic [COUNT_BITS-1:0] cnt_q [CHANNELS];
	logic [COUNT_BITS-1:0] tgt_q [SLOTS];
	logic [CHANNELS-1:0]   prev_q;
	logic [SLOTS-1:0]      done_q;
	logic [PRIO_W-1:0]     grp_q;
	logic [CHANNELS-1:0]   pump_q;
	logic [CHANNELS-1:0]   dir_q;
	logic                  running_q;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_q;
	logic      res_valid_q;
	logic      advance;

	// setup decode
	logic [CHAN_W-1:0]     wr_chan;
	logic [PRIO_W-1:0]     wr_prio_raw;
	logic [PRIO_W-1:0]     wr_prio;
	logic [CHANNELS-1:0]   wr_oh;
	logic [ML_W-1:0]       wr_ml;
	logic [KA_W-1:0]       wr_ka;
	logic [KB_W-1:0]       wr_kb;
	logic [PROD_W-1:0]     wr_prod;
	logic [TW-1:0]         wr_sum;
	logic [COUNT_BITS-1:0] wr_tgt;

	always_comb begin
		wr_chan     = cfg_data[F_CHAN_LO +: CHAN_W];
		wr_prio_raw = cfg_data[F_PRIO_LO +: PRIO_W];
		wr_prio     = (wr_prio_raw >= PRIO_NONE) ? PRIO_LAST : wr_prio_raw;
		wr_oh       = (32'(wr_chan) < CHANNELS) ? (CHANNELS'(1) << wr_chan) : '0;
		wr_ml       = cfg_data[F_ML_LO +: ML_W];
		wr_ka       = cfg_data[F_KA_LO +: KA_W];
		wr_kb       = cfg_data[F_KB_LO +: KB_W];
		wr_prod     = PROD_W'(wr_ka) * PROD_W'(wr_ml);
		wr_sum      = {{(TW-SHR_W){1'b0}}, wr_prod[PROD_W-1:8]}
			+ {{(TW-KB_W){wr_kb[KB_W-1]}}, wr_kb};
		if (wr_sum[TW-1]) begin
			wr_tgt = '0;
		end else if (wr_sum > {{(TW-COUNT_BITS){1'b0}}, CNT_MAX}) begin
			wr_tgt = CNT_MAX;
		end else begin
			wr_tgt = wr_sum[COUNT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				cfg_oh_q[s]   <= CHANNELS'(1);
				cfg_prio_q[s] <= '0;
				cfg_tgt_q[s]  <= '0;
			end
			cfg_act_q <= '0;
			cfg_dir_q <= '0;
		end else if (cfg_we) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (32'(cfg_index) == s) begin
					cfg_oh_q[s]   <= wr_oh;
					cfg_prio_q[s] <= wr_prio;
					cfg_tgt_q[s]  <= wr_tgt;
					cfg_act_q[s]  <= cfg_data[F_EN] && (32'(wr_chan) < CHANNELS);
					cfg_dir_q[s]  <= cfg_data[F_DIR];
				end
			end
		end
	end

	// handshake: input register, result register
	assign advance   = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = res_valid_q;
	assign out_item  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// next-state evaluation
	logic                  eval;
	logic [COUNT_BITS-1:0] cnt_nx [CHANNELS];
	logic [COUNT_BITS-1:0] tgt_nx [SLOTS];
	logic [COUNT_BITS-1:0] cnt_sel [SLOTS];
	logic [CHANNELS-1:0]   prev_nx;
	logic [CHANNELS-1:0]   changed;
	logic [SLOTS-1:0]      done_base;
	logic [CHANNELS-1:0]   dir_base;
	logic [SLOTS-1:0]      done_ev;
	logic [CHANNELS-1:0]   dir_ev;
	logic [CHANNELS-1:0]   pump_ev;
	logic [PRIO_W-1:0]     grp_ev;
	logic                  all_done;
	logic [SLOTS-1:0]      done_nx;
	logic [CHANNELS-1:0]   dir_nx;
	logic [CHANNELS-1:0]   pump_nx;
	logic [PRIO_W-1:0]     grp_nx;
	logic                  run_nx;

	always_comb begin
		eval      = 1'b0;
		cnt_nx    = cnt_q;
		tgt_nx    = tgt_q;
		prev_nx   = prev_q;
		done_base = done_q;
		dir_base  = dir_q;
		run_nx    = running_q;
		changed   = item_s1.encoder_levels ^ prev_q;

		if (item_s1.opcode == OP_START) begin
			eval    = 1'b1;
			run_nx  = 1'b1;
			prev_nx = item_s1.encoder_levels;
			tgt_nx  = cfg_tgt_q;
			done_base = ~cfg_act_q;
			dir_base  = '0;
			for (int c = 0; c < CHANNELS; c++) begin
				cnt_nx[c] = '0;
			end
			for (int s = 0; s < SLOTS; s++) begin
				if (cfg_act_q[s] && cfg_dir_q[s]) begin
					dir_base = dir_base | cfg_oh_q[s];
				end
			end
		end else if (running_q) begin
			eval    = 1'b1;
			prev_nx = item_s1.encoder_levels;
			for (int c = 0; c < CHANNELS; c++) begin
				if (changed[c] && cnt_q[c] != CNT_MAX) begin
					cnt_nx[c] = cnt_q[c] + COUNT_BITS'(1);
				end
			end
		end

		// pick each slot's channel count
		for (int s = 0; s < SLOTS; s++) begin
			cnt_sel[s] = '0;
			for (int c = 0; c < CHANNELS; c++) begin
				if (cfg_oh_q[s][c]) begin
					cnt_sel[s] = cnt_sel[s] | cnt_nx[c];
				end
			end
		end

		// finish slots that reached target; drop their direction lines
		done_ev = done_base;
		dir_ev  = dir_base;
		for (int s = 0; s < SLOTS; s++) begin
			if (!done_base[s] && cnt_sel[s] >= tgt_nx[s]) begin
				done_ev[s] = 1'b1;
				dir_ev     = dir_ev & ~cfg_oh_q[s];
			end
		end

		// lowest group with an unfinished slot
		grp_ev = PRIO_NONE;
		for (int s = 0; s < SLOTS; s++) begin
			if (!done_ev[s] && cfg_prio_q[s] < grp_ev) begin
				grp_ev = cfg_prio_q[s];
			end
		end
		pump_ev = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (!done_ev[s] && cfg_prio_q[s] == grp_ev) begin
				pump_ev = pump_ev | cfg_oh_q[s];
			end
		end
		all_done = &done_ev;

		done_nx = done_q;
		dir_nx  = dir_q;
		pump_nx = pump_q;
		grp_nx  = grp_q;
		if (eval) begin
			done_nx = done_ev;
			if (all_done) begin
				dir_nx  = '0;
				pump_nx = '0;
				grp_nx  = PRIO_NONE;
				run_nx  = 1'b0;
			end else begin
				dir_nx  = dir_ev;
				pump_nx = pump_ev;
				grp_nx  = grp_ev;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				cnt_q[c] <= '0;
			end
			for (int s = 0; s < SLOTS; s++) begin
				tgt_q[s] <= '0;
			end
			prev_q    <= '0;
			done_q    <= '1;
			grp_q     <= PRIO_NONE;
			pump_q    <= '0;
			dir_q     <= '0;
			running_q <= 1'b0;
		end else if (advance) begin
			cnt_q     <= cnt_nx;
			tgt_q     <= tgt_nx;
			prev_q    <= prev_nx;
			done_q    <= done_nx;
			grp_q     <= grp_nx;
			pump_q    <= pump_nx;
			dir_q     <= dir_nx;
			running_q <= run_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.pump_drive       <= pump_nx;
			res_q.direction_drive  <= dir_nx;
			res_q.pumps_enable     <= run_nx;
			res_q.current_priority <= grp_nx;
			res_q.finished_mask    <= done_nx;
			res_q.run_done         <= &done_nx;
		end
	end

	`PGDS_ASSERT_NOW(a_idle_no_drive, !running_q, (pump_q == '0) && (dir_q == '0), "drive bits set while no run is active")
	`PGDS_ASSERT_NOW(a_done_parks_group, &done_q, (grp_q == PRIO_NONE) && !running_q, "all slots finished but group pointer or run flag left set")
	`PGDS_ASSERT_NOW(a_stall_blocks_input, valid_s1 && res_valid_q && !out_ready, !in_ready, "input taken while held item cannot move")
	`PGDS_ASSERT_NEXT(a_sample_keeps_done, advance && item_s1.opcode == OP_SAMPLE, (done_q & $past(done_q)) == $past(done_q), "finished slot reopened by a sample item")

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import pgds_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_PER_PHASE = 205;
	localparam int PHASES = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_LOGGED = 200;

	typedef enum logic {ROW_SETUP, ROW_ITEM} row_kind_e;
	typedef enum int {SETUP_SMALL, SETUP_WILD, SETUP_EXTREME, SETUP_SHARED} setup_style_e;

	typedef struct packed {
		row_kind_e            kind;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     word;
		logic                 typed;
		out_item_t            want;
	} plan_row_t;

	localparam out_item_t IDLE_STATUS = '{
		pump_drive: '0,
		direction_drive: '0,
		pumps_enable: 1'b0,
		current_priority: PRIO_W'(SLOTS),
		finished_mask: '1,
		run_done: 1'b1
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_item;

	// travels with the item on the input channel
	logic                 item_typed;
	out_item_t            item_want;

	int send_pct;
	int stall_pct;
	int mismatches = 0;
	int cycle_count = 0;
	bit cfg_busy;

	out_item_t status_due[$];
	plan_row_t plan[$];

	// dispenser state as seen by the checker
	logic [CFG_W-1:0]          setup_reg [SLOTS];
	logic [COUNT_BITS_DEF-1:0] pulse_cnt [CHANNELS];
	logic [COUNT_BITS_DEF-1:0] dose_goal [SLOTS];
	logic [CHANNELS-1:0]       last_levels;
	logic [SLOTS-1:0]          slot_fin;
	logic [PRIO_W-1:0]         group_now;
	logic [CHANNELS-1:0]       pump_mask;
	logic [CHANNELS-1:0]       dir_mask;
	logic                      run_active;

	priority_group_dose_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [CFG_W-1:0] pack_setup(int ch, bit en, bit rev, int prio,
			int ml, int ka, int kb);
		logic [CFG_W-1:0] w;
		w = '0;
		w[F_CHAN_LO +: CHAN_W] = CHAN_W'(ch);
		w[F_EN] = en;
		w[F_DIR] = rev;
		w[F_PRIO_LO +: PRIO_W] = PRIO_W'(prio);
		w[F_ML_LO +: ML_W] = ML_W'(ml);
		w[F_KA_LO +: KA_W] = KA_W'(ka);
		w[F_KB_LO +: KB_W] = KB_W'(kb);
		return w;
	endfunction

	function automatic logic [CHAN_W-1:0] slot_chan(int s);
		return setup_reg[s][F_CHAN_LO +: CHAN_W];
	endfunction

	function automatic logic slot_live(int s);
		return setup_reg[s][F_EN] && (slot_chan(s) < CHANNELS);
	endfunction

	function automatic logic [PRIO_W-1:0] slot_group(int s);
		logic [PRIO_W-1:0] p;
		p = setup_reg[s][F_PRIO_LO +: PRIO_W];
		return (p >= SLOTS) ? PRIO_W'(SLOTS - 1) : p;
	endfunction

	function automatic logic [COUNT_BITS_DEF-1:0] dose_goal_of(int s);
		logic [27:0] prod;
		int t;
		prod = 28'(setup_reg[s][F_KA_LO +: KA_W]) * 28'(setup_reg[s][F_ML_LO +: ML_W]);
		t = int'(prod >> 8) + int'($signed(setup_reg[s][F_KB_LO +: KB_W]));
		if (t < 0)
			return '0;
		if (t > (1 << COUNT_BITS_DEF) - 1)
			return '1;
		return COUNT_BITS_DEF'(t);
	endfunction

	// finish reached slots, pick the lowest live group, drive its pumps
	function automatic void settle_slots();
		int g;
		for (int s = 0; s < SLOTS; s++) begin
			if (!slot_fin[s] && pulse_cnt[slot_chan(s)] >= dose_goal[s]) begin
				slot_fin[s] = 1'b1;
				dir_mask[slot_chan(s)] = 1'b0;
			end
		end
		g = SLOTS;
		for (int s = 0; s < SLOTS; s++)
			if (!slot_fin[s] && slot_group(s) < g)
				g = slot_group(s);
		group_now = PRIO_W'(g);
		pump_mask = '0;
		for (int s = 0; s < SLOTS; s++)
			if (!slot_fin[s] && slot_group(s) == g)
				pump_mask[slot_chan(s)] = 1'b1;
		if (&slot_fin) begin
			run_active = 1'b0;
			pump_mask = '0;
			dir_mask = '0;
			group_now = PRIO_W'(SLOTS);
		end
	endfunction

	function automatic out_item_t advance_dispenser(in_item_t it);
		out_item_t r;
		logic [CHANNELS-1:0] flips;
		if (it.opcode == OP_START) begin
			for (int c = 0; c < CHANNELS; c++)
				pulse_cnt[c] = '0;
			last_levels = it.encoder_levels;
			slot_fin = '0;
			dir_mask = '0;
			for (int s = 0; s < SLOTS; s++) begin
				dose_goal[s] = dose_goal_of(s);
				if (!slot_live(s))
					slot_fin[s] = 1'b1;
				else if (setup_reg[s][F_DIR])
					dir_mask[slot_chan(s)] = 1'b1;
			end
			run_active = 1'b1;
			settle_slots();
		end else if (run_active) begin
			flips = it.encoder_levels ^ last_levels;
			for (int c = 0; c < CHANNELS; c++)
				if (flips[c] && pulse_cnt[c] != '1)
					pulse_cnt[c] = pulse_cnt[c] + 1'b1;
			last_levels = it.encoder_levels;
			settle_slots();
		end
		r.pump_drive = pump_mask;
		r.direction_drive = dir_mask;
		r.pumps_enable = run_active;
		r.current_priority = group_now;
		r.finished_mask = slot_fin;
		r.run_done = &slot_fin;
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] draw_setup(setup_style_e st);
		logic [CFG_W-1:0] w;
		int ch;
		ch = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
		if (st == SETUP_SHARED)
			ch = $urandom_range(0, 2);
		w = pack_setup(ch, $urandom_range(0, 6) != 0, 1'($urandom_range(0, 1)),
			$urandom_range(0, 7), $urandom_range(0, 40), $urandom_range(0, 'h180),
			int'($urandom_range(0, 24)) - 12);
		if (st == SETUP_WILD) begin
			w = CFG_W'({$urandom(), $urandom()});
		end else if (st == SETUP_EXTREME) begin
			case ($urandom_range(0, 3))
				0: w = '1;
				1: w = '0;
				2: w = pack_setup(ch, 1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, 7),
					'hFFF, 'hFFFF, -32768);
				default: ;
			endcase
		end
		return w;
	endfunction

	function automatic plan_row_t item_row(logic op, logic [CHANNELS-1:0] lv);
		plan_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.word = CFG_W'({op, lv});
		return r;
	endfunction

	function automatic plan_row_t status_row(logic op, logic [CHANNELS-1:0] lv);
		plan_row_t r;
		r = item_row(op, lv);
		r.typed = 1'b1;
		r.want = IDLE_STATUS;
		return r;
	endfunction

	function automatic plan_row_t setup_row(int idx, logic [CFG_W-1:0] w);
		plan_row_t r;
		r = '0;
		r.kind = ROW_SETUP;
		r.index = CFG_IDX_W'(idx);
		r.word = w;
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [CHANNELS-1:0] got,
			logic [CHANNELS-1:0] want);
		mismatches++;
		// hold the log to a readable size
		if (mismatches <= MAX_LOGGED)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	// drop valid, let every pending result drain, then let the pipe settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [CFG_W-1:0] w);
		if (!cfg_busy)
			wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= w;
		@(posedge clk);
		cfg_busy = 1'b1;
	endtask

	task automatic send_item(in_item_t it, logic typed, out_item_t want);
		if (cfg_busy) begin
			cfg_we <= 1'b0;
			cfg_busy = 1'b0;
		end
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		item_typed <= typed;
		item_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin : watch
		out_item_t predicted;
		out_item_t want;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				setup_reg[s] = '0;
				dose_goal[s] = '0;
			end
			for (int c = 0; c < CHANNELS; c++)
				pulse_cnt[c] = '0;
			last_levels = '0;
			slot_fin = '1;
			group_now = PRIO_W'(SLOTS);
			pump_mask = '0;
			dir_mask = '0;
			run_active = 1'b0;
		end else begin
			if (cfg_we && cfg_index < SLOTS)
				setup_reg[cfg_index] = cfg_data;
			if (in_valid && in_ready) begin
				predicted = advance_dispenser(in_item);
				status_due.push_back(item_typed ? item_want : predicted);
			end
			if (out_valid && out_ready) begin
				if (status_due.size() == 0) begin
					note_mismatch("result with nothing pending", out_item.pump_drive, '0);
				end else begin
					want = status_due.pop_front();
					if (out_item.pump_drive !== want.pump_drive)
						note_mismatch("pump_drive", out_item.pump_drive, want.pump_drive);
					if (out_item.direction_drive !== want.direction_drive)
						note_mismatch("direction_drive", out_item.direction_drive,
							want.direction_drive);
					if (out_item.pumps_enable !== want.pumps_enable)
						note_mismatch("pumps_enable", CHANNELS'(out_item.pumps_enable),
							CHANNELS'(want.pumps_enable));
					if (out_item.current_priority !== want.current_priority)
						note_mismatch("current_priority", CHANNELS'(out_item.current_priority),
							CHANNELS'(want.current_priority));
					if (out_item.finished_mask !== want.finished_mask)
						note_mismatch("finished_mask", CHANNELS'(out_item.finished_mask),
							CHANNELS'(want.finished_mask));
					if (out_item.run_done !== want.run_done)
						note_mismatch("run_done", CHANNELS'(out_item.run_done),
							CHANNELS'(want.run_done));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		in_item_t it;
		int sent;
		int burst;
		setup_style_e style;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_item <= '0;
		item_typed <= 1'b0;
		item_want <= '0;
		send_pct = 0;
		stall_pct = 0;
		cfg_busy = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle after reset, an all-disabled run, then the shaped setup:
		// shared channel, clamp high, channel out of range, zero target,
		// priority out of range, empty groups, finish outside the group, restart
		plan = '{
			status_row(OP_SAMPLE, 24'hABCDEF),
			status_row(OP_START, 24'hFFFFFF),
			status_row(OP_SAMPLE, 24'h123456),
			setup_row(0, pack_setup(3, 1'b1, 1'b1, 2, 4, 'h100, 0)),
			setup_row(1, pack_setup(3, 1'b1, 1'b0, 2, 0, 0, 2)),
			setup_row(2, pack_setup(5, 1'b1, 1'b1, 7, 'hFFF, 'hFFFF, 'h7FFF)),
			setup_row(3, pack_setup(31, 1'b1, 1'b1, 0, 0, 0, 0)),
			setup_row(4, pack_setup(7, 1'b1, 1'b1, 0, 0, 0, -32768)),
			setup_row(5, pack_setup(10, 1'b1, 1'b0, 4, 0, 0, 1)),
			item_row(OP_START, 24'h000000),
			item_row(OP_SAMPLE, 24'h000400),
			item_row(OP_SAMPLE, 24'h000408),
			item_row(OP_SAMPLE, 24'h000400),
			item_row(OP_SAMPLE, 24'hFFFFFF),
			item_row(OP_SAMPLE, 24'h000000),
			item_row(OP_SAMPLE, 24'hFFFFFF),
			item_row(OP_START, 24'h800001),
			item_row(OP_SAMPLE, 24'h7FFFFE),
			item_row(OP_SAMPLE, 24'h7FFFFE)
		};

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETUP)
				write_reg(plan[i].index, plan[i].word);
			else
				send_item(in_item_t'(plan[i].word[$bits(in_item_t)-1:0]), plan[i].typed,
					plan[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_pct = 0;  stall_pct = 0;  end
				1: begin send_pct = 78; stall_pct = 0;  end
				2: begin send_pct = 0;  stall_pct = 78; end
				default: begin send_pct = 7; stall_pct = 7; end
			endcase
			case (p)
				4: style = SETUP_WILD;
				5: style = SETUP_EXTREME;
				6: style = SETUP_SHARED;
				default: style = SETUP_SMALL;
			endcase
			for (int s = 0; s < SLOTS; s++)
				write_reg(s, draw_setup(style));

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				it.opcode = OP_START;
				it.encoder_levels = CHANNELS'($urandom());
				send_item(it, 1'b0, '0);
				sent++;
				// short bursts restart a run early, long ones idle past its end
				burst = $urandom_range(4, 80);
				repeat (burst) begin
					it.opcode = ($urandom_range(0, 99) < 3) ? OP_START : OP_SAMPLE;
					it.encoder_levels = CHANNELS'($urandom());
					send_item(it, 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 39) == 0)
					wait_quiet();
			end
		end

		wait_quiet();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
